// File: src/wildcard_pattern_matcher_defines.svh
// Assertion macros for the wildcard pattern matcher
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define WPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/wpm_pkg.sv
// Types and constants shared by the wildcard pattern matcher
`timescale 1ns / 1ps
package wpm_pkg;

  localparam int unsigned MaxPattern = 64;
  localparam int unsigned LenW       = $clog2(MaxPattern + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } wpm_cmd_e;

  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_ANY_ONE = 2'd1,
    KIND_ANY_RUN = 2'd2
  } wpm_kind_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REARM,
    OP_STEP,
    OP_SETTLE
  } wpm_op_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETTLE
  } wpm_state_e;

  // broadcast to every cell
  typedef struct packed {
    wpm_op_e    op;
    logic       wr;
    logic [1:0] kind;
    logic [7:0] chr;
  } wpm_ctrl_t;

  // per-cell position info
  typedef struct packed {
    logic used;
    logic wr_sel;
    logic first;
  } wpm_slot_t;

  // handed from cell i to position i+1
  typedef struct packed {
    logic run;
    logic hit;
  } wpm_link_t;

endpackage

// File: src/wpm_in_if.sv
// Input channel: command, symbol kind and byte with valid/ready
`timescale 1ns / 1ps
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] symbol_kind;
  logic [7:0] symbol_char;

  modport source (output valid, output command, output symbol_kind, output symbol_char,
                  input ready);
  modport sink   (input valid, input command, input symbol_kind, input symbol_char,
                  output ready);
endinterface

// File: src/wpm_out_if.sv
// Result channel: match and overflow flags with valid/ready
`timescale 1ns / 1ps
interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// File: src/wpm_cell.sv
// One pattern position: stored symbol plus its active bit
`timescale 1ns / 1ps
module wpm_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wpm_pkg::wpm_ctrl_t ctrl_i,
  input  wpm_pkg::wpm_slot_t slot_i,
  input  wpm_pkg::wpm_link_t prev_i,
  output wpm_pkg::wpm_link_t next_o,
  output logic              act_o,
  output logic              chg_o
);

  logic [1:0] kind_q;
  logic [7:0] chr_q;
  logic       act_q, act_d;
  logic       live, is_run, is_any;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr && slot_i.wr_sel) begin
      kind_q <= ctrl_i.kind;
      chr_q  <= ctrl_i.chr;
    end
  end

  assign live   = act_q & slot_i.used;
  assign is_run = (kind_q == wpm_pkg::KIND_ANY_RUN);
  assign is_any = (kind_q == wpm_pkg::KIND_ANY_ONE);

  assign next_o.run = live & is_run;
  assign next_o.hit = live & (is_run | is_any | (chr_q == ctrl_i.chr));

  // a star upstream would still turn this position on
  assign chg_o = prev_i.run & ~act_q;
  assign act_o = act_q;

  always_comb begin
    unique case (ctrl_i.op)
      wpm_pkg::OP_HOLD:   act_d = act_q;
      wpm_pkg::OP_REARM:  act_d = slot_i.first;
      wpm_pkg::OP_STEP:   act_d = next_o.run | prev_i.hit;
      wpm_pkg::OP_SETTLE: act_d = act_q | prev_i.run;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

endmodule

// File: src/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: control, cell chain, result register
`timescale 1ns / 1ps
`include "wildcard_pattern_matcher_defines.svh"
// Whole-string matcher for patterns of literal bytes, '?' and '*', held in a chain of
// wpm_pkg::MaxPattern cells, one per pattern position, each with its own active bit.
// Every transaction is applied first (load or rearm, or one text-byte step), then
// star closure ripples one cell per cycle until nothing changes, and only then is
// the next transaction taken. After reset the start position is armed before the
// first transaction is taken. A result transaction is produced only for end of
// text and sits in an output register, so the next item is taken while it waits,
// as long as the result is drained first or in the same cycle.
module wildcard_pattern_matcher (
  input  logic          clk_i,
  input  logic          rst_ni,
  wpm_in_if.sink        in_i,
  wpm_out_if.source     out_o
);

  localparam int unsigned N = wpm_pkg::MaxPattern;

  wpm_pkg::wpm_state_e        state_q, state_d;
  wpm_pkg::wpm_ctrl_t         ctrl;
  wpm_pkg::wpm_slot_t         slot [N];
  wpm_pkg::wpm_link_t         link [N+1];

  logic [wpm_pkg::LenW-1:0]   len_q, len_d;
  logic                       ovf_q, ovf_d;
  logic                       act_end_q, act_end_d;
  logic [N-1:0]               act_vec, chg_vec;
  logic [N:0]                 pos_vec, pos_mask;
  logic                       chg_any, acc, full;
  logic                       out_vld_q, matched_q, out_ovf_q;

  assign acc  = in_i.valid & in_i.ready;
  assign full = (len_q == wpm_pkg::LenW'(N));
  assign in_i.ready = (state_q == wpm_pkg::ST_IDLE) & (~out_vld_q | out_o.ready);

  assign link[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign slot[g].used   = (wpm_pkg::LenW'(g) < len_q);
    assign slot[g].wr_sel = (wpm_pkg::LenW'(g) == len_q);
    assign slot[g].first  = (g == 0);
    assign pos_mask[g]    = (wpm_pkg::LenW'(g) <= len_q);

    wpm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .slot_i (slot[g]),
      .prev_i (link[g]),
      .next_o (link[g+1]),
      .act_o  (act_vec[g]),
      .chg_o  (chg_vec[g])
    );
  end

  assign pos_mask[N] = full;
  assign pos_vec     = {act_end_q, act_vec};
  assign chg_any     = (|chg_vec) | (link[N].run & ~act_end_q);

  // control: next state, cell op, length and overflow
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    ctrl.op     = wpm_pkg::OP_HOLD;
    ctrl.wr     = 1'b0;
    ctrl.kind   = in_i.symbol_kind;
    ctrl.chr    = in_i.symbol_char;
    unique case (state_q)
      wpm_pkg::ST_INIT: begin
        ctrl.op = wpm_pkg::OP_REARM;
        state_d = wpm_pkg::ST_SETTLE;
      end
      wpm_pkg::ST_IDLE: begin
        if (acc) begin
          state_d = wpm_pkg::ST_SETTLE;
          unique case (in_i.command)
            wpm_pkg::CMD_CLEAR: begin
              ctrl.op = wpm_pkg::OP_REARM;
              len_d   = '0;
              ovf_d   = 1'b0;
            end
            wpm_pkg::CMD_APPEND: begin
              ctrl.op = wpm_pkg::OP_REARM;
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                ctrl.wr = 1'b1;
                len_d   = len_q + wpm_pkg::LenW'(1);
              end
            end
            wpm_pkg::CMD_TEXT: ctrl.op = wpm_pkg::OP_STEP;
            wpm_pkg::CMD_END:  ctrl.op = wpm_pkg::OP_REARM;
          endcase
        end
      end
      wpm_pkg::ST_SETTLE: begin
        ctrl.op = wpm_pkg::OP_SETTLE;
        if (!chg_any) begin
          state_d = wpm_pkg::ST_IDLE;
        end
      end
      default: state_d = wpm_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    unique case (ctrl.op)
      wpm_pkg::OP_HOLD:   act_end_d = act_end_q;
      wpm_pkg::OP_REARM:  act_end_d = 1'b0;
      wpm_pkg::OP_STEP:   act_end_d = link[N].hit;
      wpm_pkg::OP_SETTLE: act_end_d = act_end_q | link[N].run;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wpm_pkg::ST_INIT;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      act_end_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      act_end_q <= act_end_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (acc && (in_i.command == wpm_pkg::CMD_END)) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && (in_i.command == wpm_pkg::CMD_END)) begin
      matched_q <= pos_vec[len_q];
      out_ovf_q <= ovf_q;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.matched          = matched_q;
  assign out_o.pattern_overflow = out_ovf_q;

  `WPM_ASSERT_SAME(a_idle_closed, state_q == wpm_pkg::ST_IDLE, !chg_any, "idle before closure done")
  `WPM_ASSERT_SAME(a_len_cap, 1'b1, len_q <= wpm_pkg::LenW'(N), "pattern length past capacity")
  `WPM_ASSERT_SAME(a_beyond_len, 1'b1, (pos_vec & ~pos_mask) == '0, "position past length active")
  `WPM_ASSERT_NEXT(a_end_result, acc && (in_i.command == wpm_pkg::CMD_END), out_vld_q, "no result")
  `WPM_ASSERT_SAME(a_acc_idle, acc, state_q == wpm_pkg::ST_IDLE, "transaction taken while busy")

endmodule
